[rtl/stc_pkg.sv]
// Package: shared types, codes and constants of the space-time constraint table.
package stc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int LOC_BITS_DEF    = 20;

    localparam int CMD_W   = 2;
    localparam int LOC_W   = 20;
    localparam int TIME_W  = 16;
    localparam int BOUND_W = 15;
    localparam int LOC_EXT_W = 32;

    localparam logic [BOUND_W-1:0] BOUND_MAX = 15'h7fff;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_PLAIN = 2'd0,
        CMD_INS_TRAIN = 2'd1,
        CMD_QUERY     = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // time part of one stored entry
    typedef struct packed {
        logic signed [TIME_W-1:0] start;
        logic signed [TIME_W-1:0] stop;
        logic                     open;
        logic                     train;
        logic                     single;
    } t_span;

    typedef struct packed {
        logic signed [TIME_W-1:0] qtime;
        logic                     body_only;
    } t_query;

endpackage

[rtl/stc_ifs.sv]
// Interfaces: command channel and result channel (valid/ready words).
interface stc_cmd_if
    import stc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [LOC_W-1:0]         location;
    logic signed [TIME_W-1:0] start_time;
    logic signed [TIME_W-1:0] end_time;
    logic                     end_open;
    logic signed [TIME_W-1:0] query_time;
    logic                     body_only;

    modport source (output valid, cmd, location, start_time, end_time, end_open,
                    query_time, body_only, input ready);
    modport sink   (input valid, cmd, location, start_time, end_time, end_open,
                    query_time, body_only, output ready);
endinterface

interface stc_res_if
    import stc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               constrained;
    logic               table_full;
    logic [BOUND_W-1:0] min_length;
    logic [BOUND_W-1:0] latest_step;

    modport source (output valid, constrained, table_full, min_length, latest_step,
                    input ready);
    modport sink   (input valid, constrained, table_full, min_length, latest_step,
                    output ready);
endinterface

[rtl/stc_entry_mem.sv]
// Entry memory: one write port, one registered read port.
module stc_entry_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 55
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/stc_match.sv]
// Match unit: checks one stored entry against the pending query.
module stc_match
    import stc_pkg::*;
#(
    parameter int LOC_BITS = LOC_BITS_DEF
) (
    input  logic                i_valid,
    input  logic [LOC_BITS-1:0] i_entry_loc,
    input  t_span               i_entry_span,
    input  logic [LOC_BITS-1:0] i_loc,
    input  t_query              i_query,
    output logic                o_hit
);
    logic covers;
    logic counted;

    always_comb begin
        if (i_entry_span.single) begin
            covers = (i_query.qtime == i_entry_span.start);
        end else begin
            covers = (i_entry_span.start <= i_query.qtime) &&
                     (i_entry_span.open || (i_query.qtime < i_entry_span.stop));
        end
        // plain entries drop out of body-only queries
        counted = i_entry_span.train || !i_query.body_only;
        o_hit   = i_valid && (i_entry_loc == i_loc) && counted && covers;
    end
endmodule

[rtl/spacetime_constraint_table_core.sv]
// Top level: space-time constraint table with a sequential query scan.
//
//   channel   | dir | handshake     | word
//   i_cmd_if  | in  | valid/ready   | cmd, location, times, end_open, body_only
//   o_res_if  | out | valid/ready   | constrained, table_full, min_length, latest_step
//   i_cfg_*   | in  | write enable  | goal cell index
//
// Insert and no-op words go from idle to done and back to idle; a query goes through scan,
// which reads each stored entry in turn through the single read port and match unit, then
// done. The result word becomes valid in the same cycle as the block is back in idle.
// Reset is synchronous; the entry memory needs no clearing, entry_count resets to zero.
// A new word is taken in idle even while the previous result waits on o_res_if;
// done then holds until the result register frees up.
module spacetime_constraint_table_core
    import stc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int LOC_BITS    = LOC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LOC_W-1:0] i_cfg_wdata,
    stc_cmd_if.sink          i_cmd_if,
    stc_res_if.source        o_res_if
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $bits(t_span);
    localparam int EW = LOC_BITS + SW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_rd_valid, n_rd_valid;
    logic               r_hit, n_hit;
    logic               r_full, n_full;
    logic [BOUND_W-1:0] r_floor, n_floor;
    logic [BOUND_W-1:0] r_latest, n_latest;
    logic [LOC_W-1:0]   r_goal;
    logic [LOC_BITS-1:0] r_q_loc, n_q_loc;
    t_query             r_query, n_query;
    logic               r_out_valid, n_out_valid;
    logic               r_out_con, n_out_con;
    logic               r_out_full, n_out_full;
    logic [BOUND_W-1:0] r_out_min, n_out_min;
    logic [BOUND_W-1:0] r_out_late, n_out_late;

    logic [LOC_EXT_W-1:0] in_loc_ext, goal_ext;
    logic [LOC_BITS-1:0]  in_loc, goal_loc;
    t_span                new_span;
    logic signed [TIME_W:0] stop_ext, stop_sat, eff;
    logic                 mem_we;
    logic [EW-1:0]        mem_rdata;
    logic [LOC_BITS-1:0]  rd_loc;
    t_span                rd_span;
    logic                 hit;

    assign in_loc_ext = {{(LOC_EXT_W - LOC_W){1'b0}}, i_cmd_if.location};
    assign goal_ext   = {{(LOC_EXT_W - LOC_W){1'b0}}, r_goal};
    assign in_loc     = in_loc_ext[LOC_BITS-1:0];
    assign goal_loc   = goal_ext[LOC_BITS-1:0];

    // entry built from the incoming insert word; the effective end is start + 1 for a single step
    always_comb begin
        new_span.start  = i_cmd_if.start_time;
        new_span.stop   = i_cmd_if.end_time;
        new_span.open   = i_cmd_if.end_open;
        new_span.train  = (t_cmd'(i_cmd_if.cmd) == CMD_INS_TRAIN);
        new_span.single = (t_cmd'(i_cmd_if.cmd) == CMD_INS_PLAIN) && !i_cmd_if.end_open &&
                          (i_cmd_if.end_time == '0);
        if (new_span.single) begin
            stop_ext = {i_cmd_if.start_time[TIME_W-1], i_cmd_if.start_time} + 17'sd1;
        end else begin
            stop_ext = {i_cmd_if.end_time[TIME_W-1], i_cmd_if.end_time};
        end
        stop_sat = (stop_ext > $signed({2'b00, BOUND_MAX})) ? $signed({2'b00, BOUND_MAX})
                                                            : stop_ext;
        eff      = i_cmd_if.end_open ? $signed({2'b00, BOUND_MAX}) : stop_sat;
    end

    stc_entry_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({in_loc, new_span}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign rd_loc  = mem_rdata[EW-1:SW];
    assign rd_span = t_span'(mem_rdata[SW-1:0]);

    stc_match #(
        .LOC_BITS (LOC_BITS)
    ) u_match (
        .i_valid      (r_rd_valid),
        .i_entry_loc  (rd_loc),
        .i_entry_span (rd_span),
        .i_loc        (r_q_loc),
        .i_query      (r_query),
        .o_hit        (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_valid  = r_rd_valid;
        n_hit       = r_hit;
        n_full      = r_full;
        n_floor     = r_floor;
        n_latest    = r_latest;
        n_q_loc     = r_q_loc;
        n_query     = r_query;
        n_out_valid = r_out_valid;
        n_out_con   = r_out_con;
        n_out_full  = r_out_full;
        n_out_min   = r_out_min;
        n_out_late  = r_out_late;
        mem_we      = 1'b0;
        i_cmd_if.ready = 1'b0;

        if (r_out_valid && o_res_if.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                i_cmd_if.ready = 1'b1;
                if (i_cmd_if.valid) begin
                    n_q_loc          = in_loc;
                    n_query.qtime    = i_cmd_if.query_time;
                    n_query.body_only = i_cmd_if.body_only;
                    n_hit            = 1'b0;
                    n_full           = 1'b0;
                    n_idx            = '0;
                    n_rd_valid       = 1'b0;
                    n_state          = ST_DONE;
                    unique case (t_cmd'(i_cmd_if.cmd)) inside
                        CMD_INS_PLAIN, CMD_INS_TRAIN: begin
                            if (r_count == FULL_COUNT) begin
                                n_full = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                if (in_loc == goal_loc && eff > $signed({2'b00, r_floor})) begin
                                    n_floor = eff[BOUND_W-1:0];
                                end
                                if (!i_cmd_if.end_open &&
                                    eff > $signed({2'b00, r_latest})) begin
                                    n_latest = eff[BOUND_W-1:0];
                                end
                            end
                        end
                        CMD_QUERY: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read of entry r_idx is issued now and compared in the next cycle, from the registered read data
                if (hit) begin
                    n_hit = 1'b1;
                end
                if (r_idx < r_count) begin
                    n_idx      = r_idx + 1'b1;
                    n_rd_valid = 1'b1;
                end else begin
                    n_rd_valid = 1'b0;
                    if (!r_rd_valid) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res_if.ready) begin
                    n_out_valid = 1'b1;
                    n_out_con   = r_hit;
                    n_out_full  = r_full;
                    n_out_min   = r_floor;
                    n_out_late  = r_latest;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_full      <= 1'b0;
            r_floor     <= '0;
            r_latest    <= '0;
            r_goal      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_valid  <= n_rd_valid;
            r_hit       <= n_hit;
            r_full      <= n_full;
            r_floor     <= n_floor;
            r_latest    <= n_latest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_goal <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_loc    <= n_q_loc;
        r_query    <= n_query;
        r_out_con  <= n_out_con;
        r_out_full <= n_out_full;
        r_out_min  <= n_out_min;
        r_out_late <= n_out_late;
    end

    assign o_res_if.valid       = r_out_valid;
    assign o_res_if.constrained = r_out_con;
    assign o_res_if.table_full  = r_out_full;
    assign o_res_if.min_length  = r_out_min;
    assign o_res_if.latest_step = r_out_late;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_if.valid) |-> $past(r_state == ST_DONE))
        else $error("result word not loaded from done state");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_if.valid && o_res_if.table_full |-> r_count == FULL_COUNT)
        else $error("table_full reported with free entries");

    a_latest_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_latest >= $past(r_latest))
        else $error("latest step went down");
`endif
endmodule

[tb/tb_spacetime_constraint_table_core.sv]
// Testbench of the space-time constraint table: directed and random words, predictor checked.
module tb_spacetime_constraint_table_core;
    timeunit 1ns;
    timeprecision 1ps;
    import stc_pkg::*;

    localparam int DEPTH   = TABLE_DEPTH_DEF;
    localparam int SAT     = int'(BOUND_MAX);
    // entries kept free during the first random phases for the saturating tail words
    localparam int INS_CAP = DEPTH - 4;

    typedef struct {
        t_cmd                     cmd;
        logic [LOC_W-1:0]         location;
        logic signed [TIME_W-1:0] start_time;
        logic signed [TIME_W-1:0] end_time;
        logic                     end_open;
        logic signed [TIME_W-1:0] query_time;
        logic                     body_only;
    } cmd_word_t;

    typedef struct packed {
        logic               constrained;
        logic               table_full;
        logic [BOUND_W-1:0] min_length;
        logic [BOUND_W-1:0] latest_step;
    } answer_t;

    typedef struct {
        logic [LOC_W-1:0] loc;
        int               start;
        int               stop;
        bit               open;
        bit               train;
        bit               single;
    } stored_span_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LOC_W-1:0] i_cfg_wdata;

    stc_cmd_if cmd_if ();
    stc_res_if res_if ();

    spacetime_constraint_table_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_if    (cmd_if),
        .o_res_if    (res_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // predictor copy of the table
    stored_span_t     span_store [DEPTH];
    int               n_entries;
    int               min_len_now;
    int               latest_now;
    logic [LOC_W-1:0] goal_loc;

    cmd_word_t        word_q [$];
    answer_t          answer_q [$];
    stored_span_t     planned_q [$];
    cmd_word_t        cur_word;
    answer_t          want;
    logic [LOC_W-1:0] loc_pool [8];
    int               ins_planned;
    int               snd_idle_pct;
    int               rcv_idle_pct;

    int n_err;
    int n_checked;
    int n_stored;
    int n_full;
    int n_query;
    int n_blocked;
    int n_goal_writes;

    function automatic answer_t table_answer(input cmd_word_t w);
        answer_t      r;
        stored_span_t s;
        int           eff;
        int           qt;
        int           k;
        bit           hit;
        r   = '0;
        hit = 1'b0;
        qt  = w.query_time;
        case (w.cmd) inside
            CMD_INS_PLAIN, CMD_INS_TRAIN: begin
                if (n_entries >= DEPTH) begin
                    r.table_full = 1'b1;
                    n_full++;
                end else begin
                    s.loc    = w.location;
                    s.start  = w.start_time;
                    s.open   = w.end_open;
                    s.train  = (w.cmd == CMD_INS_TRAIN);
                    s.single = (w.cmd == CMD_INS_PLAIN) && !w.end_open && (w.end_time == 0);
                    s.stop   = s.single ? s.start + 1 : int'(w.end_time);
                    span_store[n_entries] = s;
                    n_entries++;
                    n_stored++;
                    eff = s.open ? SAT : (s.stop > SAT ? SAT : s.stop);
                    if (s.loc == goal_loc && eff > min_len_now)
                        min_len_now = eff;
                    if (!s.open && eff > latest_now)
                        latest_now = eff;
                end
            end
            CMD_QUERY: begin
                n_query++;
                for (k = 0; k < n_entries; k++) begin
                    s = span_store[k];
                    if (!hit && s.loc == w.location && (s.train || !w.body_only)) begin
                        if (s.single)
                            hit = (qt == s.start);
                        else
                            hit = (s.start <= qt) && (s.open || qt < s.stop);
                    end
                end
                r.constrained = hit;
                if (hit)
                    n_blocked++;
            end
            default: ;
        endcase
        r.min_length  = BOUND_W'(min_len_now);
        r.latest_step = BOUND_W'(latest_now);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_err++;
        $display("mismatch at %0t, result %0d: %s", $time, n_checked, msg);
    endtask

    function automatic int rand_time();
        logic signed [TIME_W-1:0] v;
        v = TIME_W'($urandom);
        return int'(v);
    endfunction

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        w.cmd        = CMD_NOP;
        w.location   = LOC_W'($urandom);
        w.start_time = TIME_W'($urandom);
        w.end_time   = TIME_W'($urandom);
        w.end_open   = 1'($urandom_range(1));
        w.query_time = TIME_W'($urandom);
        w.body_only  = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic add_insert(input t_cmd c, input logic [LOC_W-1:0] loc, input int st,
                              input int en, input bit op);
        cmd_word_t    w;
        stored_span_t s;
        w            = rand_word();
        w.cmd        = c;
        w.location   = loc;
        w.start_time = TIME_W'(st);
        w.end_time   = TIME_W'(en);
        w.end_open   = op;
        word_q.push_back(w);
        s.loc    = loc;
        s.start  = st;
        s.open   = op;
        s.train  = (c == CMD_INS_TRAIN);
        s.single = (c == CMD_INS_PLAIN) && !op && (en == 0);
        s.stop   = s.single ? st + 1 : en;
        if (ins_planned < DEPTH)
            planned_q.push_back(s);
        ins_planned++;
    endtask

    task automatic add_query(input logic [LOC_W-1:0] loc, input int qt, input bit body);
        cmd_word_t w;
        w            = rand_word();
        w.cmd        = CMD_QUERY;
        w.location   = loc;
        w.query_time = TIME_W'(qt);
        w.body_only  = body;
        word_q.push_back(w);
    endtask

    // wait until every word is in and answered, then let the pipeline drain
    task automatic settle();
        do
            @(posedge i_clk);
        while (word_q.size() != 0 || cmd_if.valid || answer_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_goal(input logic [LOC_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        goal_loc = v;
        n_goal_writes++;
    endtask

    // wide_ok lets inserts take any value, open ends at the goal included
    task automatic random_segment(input int n, input int ins_pct, input bit wide_ok);
        int               k;
        int               r;
        int               st;
        int               en;
        int               qt;
        bit               op;
        t_cmd             c;
        logic [LOC_W-1:0] loc;
        stored_span_t     s;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                word_q.push_back(rand_word());
            end else if (r < 2 + ins_pct && (wide_ok || ins_planned < INS_CAP)) begin
                c   = $urandom_range(1) ? CMD_INS_TRAIN : CMD_INS_PLAIN;
                loc = ($urandom_range(7) == 0) ? LOC_W'($urandom)
                                               : loc_pool[$urandom_range(7)];
                if (wide_ok || $urandom_range(7) == 0) begin
                    st = rand_time();
                    en = rand_time();
                    op = ($urandom_range(3) == 0);
                    if (!wide_ok) begin
                        // keep both bounds clear of saturation until the tail
                        if (st > 30000)
                            st = 30000;
                        if (en > 30000)
                            en = 30000;
                        op = op && (loc != goal_loc);
                    end
                end else begin
                    st = int'($urandom_range(2200)) - 200;
                    case ($urandom_range(5))
                        0: en = 0;
                        1: en = st - int'($urandom_range(3));
                        default: en = st + int'($urandom_range(60, 1));
                    endcase
                    op = ($urandom_range(7) == 0) && (loc != goal_loc);
                end
                add_insert(c, loc, st, en, op);
            end else begin
                if (planned_q.size() > 0 && $urandom_range(3) != 0) begin
                    s   = planned_q[$urandom_range(planned_q.size() - 1)];
                    loc = s.loc;
                    case ($urandom_range(6))
                        0: qt = s.start - 1;
                        1: qt = s.start;
                        2: qt = s.start + 1;
                        3: qt = s.stop - 1;
                        4: qt = s.stop;
                        5: qt = s.stop + 1;
                        default: qt = s.start + int'($urandom_range(40));
                    endcase
                end else begin
                    loc = ($urandom_range(1) == 0) ? loc_pool[$urandom_range(7)]
                                                   : LOC_W'($urandom);
                    qt  = rand_time();
                end
                add_query(loc, qt, 1'($urandom_range(1)));
            end
        end
    endtask

    // driver: one word on the bus, predicted when it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid      <= 1'b0;
            cmd_if.cmd        <= CMD_NOP;
            cmd_if.location   <= '0;
            cmd_if.start_time <= '0;
            cmd_if.end_time   <= '0;
            cmd_if.end_open   <= 1'b0;
            cmd_if.query_time <= '0;
            cmd_if.body_only  <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                answer_q.push_back(table_answer(cur_word));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    cur_word = word_q.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.cmd        <= cur_word.cmd;
                    cmd_if.location   <= cur_word.location;
                    cmd_if.start_time <= cur_word.start_time;
                    cmd_if.end_time   <= cur_word.end_time;
                    cmd_if.end_open   <= cur_word.end_open;
                    cmd_if.query_time <= cur_word.query_time;
                    cmd_if.body_only  <= cur_word.body_only;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = answer_q.pop_front();
                if (res_if.constrained !== want.constrained)
                    report_mismatch($sformatf("constrained %0b, want %0b",
                                              res_if.constrained, want.constrained));
                if (res_if.table_full !== want.table_full)
                    report_mismatch($sformatf("table_full %0b, want %0b",
                                              res_if.table_full, want.table_full));
                if (res_if.min_length !== want.min_length)
                    report_mismatch($sformatf("min_length %0d, want %0d",
                                              res_if.min_length, want.min_length));
                if (res_if.latest_step !== want.latest_step)
                    report_mismatch($sformatf("latest_step %0d, want %0d",
                                              res_if.latest_step, want.latest_step));
            end
            n_checked++;
        end
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        n_entries     = 0;
        min_len_now   = 0;
        latest_now    = 0;
        goal_loc      = '0;
        ins_planned   = 0;
        n_err         = 0;
        n_checked     = 0;
        n_stored      = 0;
        n_full        = 0;
        n_query       = 0;
        n_blocked     = 0;
        n_goal_writes = 0;
        snd_idle_pct  = 19;
        rcv_idle_pct  = 79;
        loc_pool[0] = '0;
        loc_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            loc_pool[k] = LOC_W'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_goal(loc_pool[2]);

        add_query(loc_pool[4], 0, 1'b0);                      // empty table
        add_insert(CMD_INS_PLAIN, loc_pool[4], 10, 0, 1'b0);  // single step at 10
        add_query(loc_pool[4], 10, 1'b0);
        add_query(loc_pool[4], 10, 1'b1);                     // plain ignored on body_only
        add_query(loc_pool[4], 11, 1'b0);
        add_query(loc_pool[4], 9, 1'b0);
        add_insert(CMD_INS_TRAIN, loc_pool[5], -5, 0, 1'b0);  // train keeps end 0
        add_query(loc_pool[5], -5, 1'b1);
        add_query(loc_pool[5], 0, 1'b1);
        add_insert(CMD_INS_PLAIN, loc_pool[5], 100, 0, 1'b1); // open end beats end 0
        add_query(loc_pool[5], 32767, 1'b0);
        add_insert(CMD_INS_PLAIN, loc_pool[2], 20, 40, 1'b0); // goal raises min_length
        add_insert(CMD_INS_TRAIN, loc_pool[2], 50, 50, 1'b0); // empty span, bounds move
        add_query(loc_pool[2], 50, 1'b0);
        add_query(loc_pool[2], 39, 1'b0);
        add_insert(CMD_INS_PLAIN, '0, -32768, 0, 1'b0);
        add_query('0, -32768, 1'b0);
        add_insert(CMD_INS_TRAIN, '1, 32767, -32768, 1'b0);
        add_query('1, 32767, 1'b1);
        word_q.push_back(rand_word());                        // no-op command

        settle();
        write_goal('0);
        random_segment(600, 8, 1'b0);

        settle();
        snd_idle_pct = 79;
        rcv_idle_pct = 19;
        write_goal('1);
        random_segment(600, 8, 1'b0);

        settle();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_goal(loc_pool[3]);
        add_insert(CMD_INS_PLAIN, loc_pool[3], 5, 0, 1'b1);   // open at goal: min_length to max
        add_query(loc_pool[3], 30000, 1'b0);
        add_insert(CMD_INS_PLAIN, loc_pool[6], 32767, 0, 1'b0); // end 32768 clips
        add_query(loc_pool[6], 32767, 1'b0);
        add_query(loc_pool[6], -32768, 1'b0);
        while (ins_planned < DEPTH + 3)
            add_insert(CMD_INS_TRAIN, loc_pool[7], 0, 10, 1'b0);  // fill, then overflow
        add_query(loc_pool[7], 5, 1'b1);
        random_segment(580, 25, 1'b1);

        settle();
        repeat (DEPTH + 8) @(posedge i_clk);
        $display("checked %0d results: %0d stored, %0d dropped, %0d queries (%0d blocked)",
                 n_checked, n_stored, n_full, n_query, n_blocked);
        $display("goal written %0d times; final min_length %0d, latest_step %0d",
                 n_goal_writes, min_len_now, latest_now);
        if (n_err == 0 && answer_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(12_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/stc_pkg.sv
rtl/stc_ifs.sv
rtl/stc_entry_mem.sv
rtl/stc_match.sv
rtl/spacetime_constraint_table_core.sv
tb/tb_spacetime_constraint_table_core.sv
